### rtl/core/choff_pkg.sv
// ----------------------------------------------------------------------------
// choff_pkg
// Shared types, constants and calendar helpers for the hour offset unit.
// ----------------------------------------------------------------------------
package choff_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int YEAR_W          = 14;
	localparam int DOY_W           = 9;
	localparam int MONTH_W         = 4;
	localparam int DAY_W           = 5;
	localparam int HOUR_W          = 5;
	localparam int MINUTE_W        = 6;
	localparam int M400_W          = 9;

	localparam int YEAR_MIN        = 1900;
	localparam int YEAR_MAX        = 9999;
	localparam int DAY_HOURS       = 24;
	localparam int HOUR_MAX        = 23;
	localparam int MINUTE_MAX      = 59;
	localparam int MONTHS          = 12;
	localparam int DAYS_BASE       = 365;
	localparam int LEAP_CYCLE      = 400;

	typedef enum logic [1:0] {
		FUNC_OFFSET = 2'd0,
		FUNC_TO_MD  = 2'd1,
		FUNC_TO_DOY = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	// leap rule from the year modulo 400
	function automatic logic is_leap(input logic [M400_W-1:0] m400);
		logic hundred;
		hundred = (m400 == M400_W'(100)) || (m400 == M400_W'(200)) ||
		          (m400 == M400_W'(300));
		return (m400[1:0] == 2'b00) && !hundred;
	endfunction

	function automatic logic [DOY_W-1:0] year_len(input logic leap);
		return DOY_W'(DAYS_BASE) + DOY_W'(leap);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

### rtl/core/choff_alu.sv
// ----------------------------------------------------------------------------
// choff_alu
// Shared add/subtract unit with sign and zero flags on the result.
// ----------------------------------------------------------------------------
module choff_alu #(
	parameter int W = 18
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         neg,
	output logic         zero
);

	always_comb begin
		res  = sub ? (a - b) : (a + b);
		neg  = res[W-1];
		zero = (res == '0);
	end

endmodule

### rtl/core/calendar_hour_offset_unit.sv
// ----------------------------------------------------------------------------
// calendar_hour_offset_unit
// Gregorian ordinal-date unit: hour offset, day-of-year to month/day and back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | func year day_of_year month day hour
//          |           |                    | minute hour_offset
//  result  | out       | out_valid/out_stall| out_year out_day_of_year out_month
//          |           |                    | out_day out_hour out_minute status
//
//  One item at a time; add/subtract through one shared unit, hours split into
//  days by a constant reciprocal multiply. The year is first reduced modulo
//  400 by repeated subtraction, then checked; func 1/2 then step a month at a
//  time, while func 0 sums, takes the magnitude, divides, fixes up
//  and steps the year up or down. A bad func or year skips to done. in_stall
//  is high until the result enters the output register, so a stalled result
//  holds the unit. Reset clears the sequencer and all registers.
// ----------------------------------------------------------------------------
module calendar_hour_offset_unit #(
	parameter int OFFSET_BITS = choff_pkg::OFFSET_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           func,
	input  logic [choff_pkg::YEAR_W-1:0]         year,
	input  logic [choff_pkg::DOY_W-1:0]          day_of_year,
	input  logic [choff_pkg::MONTH_W-1:0]        month,
	input  logic [choff_pkg::DAY_W-1:0]          day,
	input  logic [choff_pkg::HOUR_W-1:0]         hour,
	input  logic [choff_pkg::MINUTE_W-1:0]       minute,
	input  logic signed [OFFSET_BITS-1:0]        hour_offset,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [choff_pkg::YEAR_W-1:0]         out_year,
	output logic [choff_pkg::DOY_W-1:0]          out_day_of_year,
	output logic [choff_pkg::MONTH_W-1:0]        out_month,
	output logic [choff_pkg::DAY_W-1:0]          out_day,
	output logic [choff_pkg::HOUR_W-1:0]         out_hour,
	output logic [choff_pkg::MINUTE_W-1:0]       out_minute,
	output logic [1:0]                           status
);

	localparam int DW    = (OFFSET_BITS + 2 > 15) ? OFFSET_BITS + 2 : 15;
	localparam int YW    = choff_pkg::YEAR_W;
	localparam int NW    = choff_pkg::DOY_W;
	localparam int MW    = choff_pkg::MONTH_W;
	localparam int DYW   = choff_pkg::DAY_W;
	localparam int HW    = choff_pkg::HOUR_W;
	localparam int MNW   = choff_pkg::MINUTE_W;
	localparam int QW    = choff_pkg::M400_W;

	// x/24 = (x/8)/3, and y/3 = (y * ceil(2^31/3)) >> 31 exactly for y < 2^31
	localparam int              YDW    = DW - 3;
	localparam int              RCP_W  = 30;
	localparam int              RCP_SH = 31;
	localparam int              PW     = YDW + RCP_W;
	localparam int              QTW    = PW - RCP_SH;
	localparam logic [RCP_W-1:0] RCP3  = 30'h2AAA_AAAB;

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_CHECK, S_TOT, S_ABS, S_DIV, S_FIX,
		S_YSTEP, S_YADD, S_MD, S_DY, S_DONE
	} state_t;

	state_t                     state_q;
	logic [1:0]                 func_q;
	logic [YW-1:0]              yy_q;
	logic [NW-1:0]              doy_q;
	logic [MW-1:0]              mon_in_q;
	logic [DYW-1:0]             dom_q;
	logic [HW-1:0]              hour_in_q;
	logic [MNW-1:0]             min_q;
	logic [OFFSET_BITS-1:0]     off_q;
	logic [DW-1:0]              d_q;
	logic [DW-1:0]              acc_q;
	logic [DYW-1:0]             rem_q;
	logic                       neg_q;
	logic [QW-1:0]              m400_q;
	logic [MW-1:0]              mon_q;
	logic [HW-1:0]              hour_q;
	choff_pkg::status_t         status_q;

	logic [DW-1:0]              alu_a, alu_b, alu_res;
	logic                       alu_sub, alu_neg, alu_zero;

	logic [YDW-1:0]             div_y;
	logic [PW-1:0]              div_prod;
	logic [QTW-1:0]             div_q;
	logic [1:0]                 div_r3;

	logic                       leap;
	logic [NW-1:0]              ylen;
	logic [DYW-1:0]             dim;
	logic                       rnz;
	logic [NW-1:0]              doy_adj;
	logic                       year_in_range;
	logic                       doy_ok, hm_ok, md_ok;
	logic                       out_free;

	assign leap    = choff_pkg::is_leap(m400_q);
	assign ylen    = choff_pkg::year_len(leap);
	assign dim     = choff_pkg::month_days(mon_q, leap);
	assign rnz     = (rem_q != '0);
	assign doy_adj = doy_q - NW'(neg_q && rnz);

	assign div_y    = acc_q[DW-1:3];
	assign div_prod = {{RCP_W{1'b0}}, div_y} * {{YDW{1'b0}}, RCP3};
	assign div_q    = div_prod[PW-1:RCP_SH];
	// y - 3q is 0..2, so two bits of it are enough
	assign div_r3   = div_y[1:0] - (div_q[1:0] + {div_q[0], 1'b0});

	assign year_in_range = (year >= YW'(choff_pkg::YEAR_MIN)) &&
	                       (year <= YW'(choff_pkg::YEAR_MAX));
	assign doy_ok = (doy_q != '0) && (doy_q <= ylen);
	assign hm_ok  = (hour_in_q <= HW'(choff_pkg::HOUR_MAX)) &&
	                (min_q <= MNW'(choff_pkg::MINUTE_MAX));
	assign md_ok  = (mon_in_q != '0) && (mon_in_q <= MW'(choff_pkg::MONTHS)) &&
	                (dom_q != '0) && (dom_q <= choff_pkg::month_days(mon_in_q, leap));

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	// operand select for the shared unit
	always_comb begin
		alu_a   = d_q;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_MOD:   alu_b = DW'(choff_pkg::LEAP_CYCLE);
			S_TOT: begin
				alu_a   = {{(DW-HW){1'b0}}, hour_in_q};
				alu_b   = {{(DW-OFFSET_BITS){off_q[OFFSET_BITS-1]}}, off_q};
				alu_sub = 1'b0;
			end
			S_ABS: begin
				alu_a = '0;
				alu_b = acc_q;
			end
			S_FIX: begin
				alu_a   = {{(DW-NW){1'b0}}, doy_adj};
				alu_b   = acc_q;
				alu_sub = neg_q;
			end
			S_YSTEP: alu_b = {{(DW-NW){1'b0}}, ylen};
			S_YADD: begin
				alu_b   = {{(DW-NW){1'b0}}, ylen};
				alu_sub = 1'b0;
			end
			S_MD:    alu_b = {{(DW-DYW){1'b0}}, dim};
			S_DY: begin
				alu_b   = {{(DW-DYW){1'b0}}, dim};
				alu_sub = 1'b0;
			end
			default: alu_sub = 1'b1;
		endcase
	end

	choff_alu #(.W(DW)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.res  (alu_res),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			func_q          <= '0;
			yy_q            <= '0;
			doy_q           <= '0;
			mon_in_q        <= '0;
			dom_q           <= '0;
			hour_in_q       <= '0;
			min_q           <= '0;
			off_q           <= '0;
			d_q             <= '0;
			acc_q           <= '0;
			rem_q           <= '0;
			neg_q           <= 1'b0;
			m400_q          <= '0;
			mon_q           <= '0;
			hour_q          <= '0;
			status_q        <= choff_pkg::STAT_OK;
			out_valid       <= 1'b0;
			out_year        <= '0;
			out_day_of_year <= '0;
			out_month       <= '0;
			out_day         <= '0;
			out_hour        <= '0;
			out_minute      <= '0;
			status          <= '0;
		end else begin
			// in S_DONE the result register is refilled instead
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q    <= func;
						yy_q      <= year;
						doy_q     <= day_of_year;
						mon_in_q  <= month;
						dom_q     <= day;
						hour_in_q <= hour;
						min_q     <= minute;
						off_q     <= hour_offset;
						d_q       <= {{(DW-YW){1'b0}}, year};
						if (func == 2'(choff_pkg::FUNC_OFFSET) ||
						    func == 2'(choff_pkg::FUNC_TO_MD) ||
						    func == 2'(choff_pkg::FUNC_TO_DOY)) begin
							if (year_in_range) begin
								status_q <= choff_pkg::STAT_OK;
								state_q  <= S_MOD;
							end else begin
								status_q <= choff_pkg::STAT_INVALID;
								state_q  <= S_DONE;
							end
						end else begin
							status_q <= choff_pkg::STAT_INVALID;
							state_q  <= S_DONE;
						end
					end
				end
				S_MOD: begin
					if (alu_neg) begin
						m400_q  <= d_q[QW-1:0];
						state_q <= S_CHECK;
					end else begin
						d_q <= alu_res;
					end
				end
				S_CHECK: begin
					mon_q <= MW'(1);
					case (func_q)
						2'(choff_pkg::FUNC_OFFSET): begin
							if (doy_ok && hm_ok) begin
								state_q <= S_TOT;
							end else begin
								status_q <= choff_pkg::STAT_INVALID;
								state_q  <= S_DONE;
							end
						end
						2'(choff_pkg::FUNC_TO_MD): begin
							d_q <= {{(DW-NW){1'b0}}, doy_q};
							if (doy_ok) begin
								state_q <= S_MD;
							end else begin
								status_q <= choff_pkg::STAT_INVALID;
								state_q  <= S_DONE;
							end
						end
						default: begin
							d_q <= {{(DW-DYW){1'b0}}, dom_q};
							if (md_ok) begin
								state_q <= S_DY;
							end else begin
								status_q <= choff_pkg::STAT_INVALID;
								state_q  <= S_DONE;
							end
						end
					endcase
				end
				S_TOT: begin
					acc_q   <= alu_res;
					neg_q   <= alu_neg;
					state_q <= S_ABS;
				end
				S_ABS: begin
					if (neg_q)
						acc_q <= alu_res;
					rem_q   <= '0;
					state_q <= S_DIV;
				end
				// |total| split into whole days and leftover hours
				S_DIV: begin
					acc_q   <= {{(DW-QTW){1'b0}}, div_q};
					rem_q   <= {div_r3, acc_q[2:0]};
					state_q <= S_FIX;
				end
				// floor division fixup: negative with remainder borrows a day
				S_FIX: begin
					d_q <= alu_res;
					if (!neg_q)
						hour_q <= rem_q;
					else if (rnz)
						hour_q <= HW'(choff_pkg::DAY_HOURS) - rem_q;
					else
						hour_q <= '0;
					state_q <= S_YSTEP;
				end
				S_YSTEP: begin
					if (!alu_neg && !alu_zero) begin
						if (yy_q == YW'(choff_pkg::YEAR_MAX)) begin
							status_q <= choff_pkg::STAT_RANGE;
							state_q  <= S_DONE;
						end else begin
							d_q    <= alu_res;
							yy_q   <= yy_q + YW'(1);
							m400_q <= (m400_q == QW'(choff_pkg::LEAP_CYCLE - 1)) ?
							          '0 : m400_q + QW'(1);
						end
					end else if (d_q[DW-1] || d_q == '0) begin
						if (yy_q == YW'(choff_pkg::YEAR_MIN)) begin
							status_q <= choff_pkg::STAT_RANGE;
							state_q  <= S_DONE;
						end else begin
							yy_q    <= yy_q - YW'(1);
							m400_q  <= (m400_q == '0) ?
							           QW'(choff_pkg::LEAP_CYCLE - 1) : m400_q - QW'(1);
							state_q <= S_YADD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_YADD: begin
					d_q     <= alu_res;
					state_q <= S_YSTEP;
				end
				S_MD: begin
					if (mon_q < MW'(choff_pkg::MONTHS) && !alu_neg && !alu_zero) begin
						d_q   <= alu_res;
						mon_q <= mon_q + MW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DY: begin
					if (mon_q < mon_in_q) begin
						d_q   <= alu_res;
						mon_q <= mon_q + MW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						status    <= status_q;
						if (status_q != choff_pkg::STAT_OK) begin
							out_year        <= '0;
							out_day_of_year <= '0;
							out_month       <= '0;
							out_day         <= '0;
							out_hour        <= '0;
							out_minute      <= '0;
						end else begin
							out_year <= yy_q;
							case (func_q)
								2'(choff_pkg::FUNC_OFFSET): begin
									out_day_of_year <= d_q[NW-1:0];
									out_month       <= '0;
									out_day         <= '0;
									out_hour        <= hour_q;
									out_minute      <= min_q;
								end
								2'(choff_pkg::FUNC_TO_MD): begin
									out_day_of_year <= doy_q;
									out_month       <= mon_q;
									out_day         <= d_q[DYW-1:0];
									out_hour        <= '0;
									out_minute      <= '0;
								end
								default: begin
									out_day_of_year <= d_q[NW-1:0];
									out_month       <= mon_in_q;
									out_day         <= dom_q;
									out_hour        <= '0;
									out_minute      <= '0;
								end
							endcase
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/choff_checker.sv
// ----------------------------------------------------------------------------
// choff_checker
// Port-level checks for the hour offset unit, bound to the top level.
// ----------------------------------------------------------------------------
module choff_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [choff_pkg::YEAR_W-1:0]         out_year,
	input logic [choff_pkg::DOY_W-1:0]          out_day_of_year,
	input logic [choff_pkg::MONTH_W-1:0]        out_month,
	input logic [choff_pkg::DAY_W-1:0]          out_day,
	input logic [choff_pkg::HOUR_W-1:0]         out_hour,
	input logic [choff_pkg::MINUTE_W-1:0]       out_minute,
	input logic [1:0]                           status
);

	// a result leaves only through a completed handshake
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

	// one item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 2'(choff_pkg::STAT_OK)) |->
		(out_year == '0 && out_day_of_year == '0 && out_month == '0 &&
		 out_day == '0 && out_hour == '0 && out_minute == '0))
		else $error("error result carries data");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == 2'(choff_pkg::STAT_OK)) |->
		(out_year >= 14'(choff_pkg::YEAR_MIN) && out_year <= 14'(choff_pkg::YEAR_MAX) &&
		 out_day_of_year != '0 && out_day_of_year <= 9'(366)))
		else $error("ok result out of calendar range");

	a_hour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_hour <= 5'(choff_pkg::HOUR_MAX) &&
		               (status == 2'(choff_pkg::STAT_OK) ||
		                status == 2'(choff_pkg::STAT_INVALID) ||
		                status == 2'(choff_pkg::STAT_RANGE))))
		else $error("bad hour or status code");

endmodule

bind calendar_hour_offset_unit choff_checker u_choff_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.out_year        (out_year),
	.out_day_of_year (out_day_of_year),
	.out_month       (out_month),
	.out_day         (out_day),
	.out_hour        (out_hour),
	.out_minute      (out_minute),
	.status          (status)
);
